### hdl/dfs_maze_carver_defines.svh
// Assertion macros used by the maze carver RTL.
// Stand-alone header; included by files that carry concurrent checks.
`ifndef DFS_MAZE_CARVER_DEFINES_SVH
`define DFS_MAZE_CARVER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DMC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/dmc_pkg.sv
// Package for the maze carver: word types, codes, states and defaults.
// No dependencies; used by dmc_nbr and dfs_maze_carver.
package dmc_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  localparam int CFG_W   = 7;   // grid size register width
  localparam int IDX_W   = 1;   // register index width
  localparam int CELL_W  = 6;   // row / column field width on the ports
  localparam int DEPTH_W = 13;  // stack depth field width
  localparam int CMP_W   = 9;   // holds a register value and any grid size up to 256

  localparam logic [CFG_W-1:0] GRID_RESET = 7'd16;

  localparam logic [IDX_W-1:0] REG_ROWS = 1'b0;
  localparam logic [IDX_W-1:0] REG_COLS = 1'b1;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  localparam logic [2:0] KIND_STARTED  = 3'd0;
  localparam logic [2:0] KIND_WALL     = 3'd1;
  localparam logic [2:0] KIND_BACK     = 3'd2;
  localparam logic [2:0] KIND_FINISHED = 3'd3;
  localparam logic [2:0] KIND_BAD      = 3'd4;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef struct packed {
    logic              func;
    logic [CELL_W-1:0] start_row;
    logic [CELL_W-1:0] start_col;
    logic [14:0]       random_value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [CELL_W-1:0]  cell_row;
    logic [CELL_W-1:0]  cell_col;
    logic [1:0]         direction;
    logic [DEPTH_W-1:0] stack_depth;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_TOP,
    S_PROBE,
    S_DECIDE,
    S_CLEAR,
    S_SEED,
    S_EMIT
  } state_t;

  // Remainder by three: base-4 digit sum, then a small reduction.
  function automatic logic [1:0] mod3_15(input logic [14:0] v);
    logic [15:0] w;
    logic [4:0]  s;
    logic [2:0]  t;
    begin
      w = {1'b0, v};
      s = '0;
      for (int k = 0; k < 8; k++) begin
        s = s + 5'(w[2*k +: 2]);
      end
      t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
      if (t >= 3'd6) begin
        t = t - 3'd6;
      end else if (t >= 3'd3) begin
        t = t - 3'd3;
      end
      return t[1:0];
    end
  endfunction

endpackage

### hdl/dmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/dmc_nbr.sv
// Neighbor unit: cell next to a given cell on one side, and whether it is in the grid.
// Depends on dmc_pkg (direction codes).
module dmc_nbr #(
  parameter int MAX_ROWS = dmc_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = dmc_pkg::DEF_MAX_COLS
) (
  input  logic [$clog2(MAX_ROWS)-1:0]   top_row,
  input  logic [$clog2(MAX_COLS)-1:0]   top_col,
  input  logic [1:0]                    dir,
  input  logic [$clog2(MAX_ROWS+1)-1:0] rows_used,
  input  logic [$clog2(MAX_COLS+1)-1:0] cols_used,
  output logic [$clog2(MAX_ROWS)-1:0]   nbr_row,
  output logic [$clog2(MAX_COLS)-1:0]   nbr_col,
  output logic                          in_grid
);

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);

  logic [RW:0] row_x;
  logic [CW:0] col_x;
  logic [RW:0] nr;
  logic [CW:0] nc;
  logic        lo_ok;

  assign row_x = {1'b0, top_row};
  assign col_x = {1'b0, top_col};

  always_comb begin
    nr    = row_x;
    nc    = col_x;
    lo_ok = 1'b1;
    unique case (dir)
      dmc_pkg::DIR_UP: begin
        nr    = row_x - 1'b1;
        lo_ok = (top_row != '0);
      end
      dmc_pkg::DIR_DOWN: begin
        nr = row_x + 1'b1;
      end
      dmc_pkg::DIR_LEFT: begin
        nc    = col_x - 1'b1;
        lo_ok = (top_col != '0);
      end
      dmc_pkg::DIR_RIGHT: begin
        nc = col_x + 1'b1;
      end
    endcase
  end

  // Both bounds are checked: the grid may have shrunk under the walk.
  assign in_grid = lo_ok && (nr < (RW+1)'(rows_used)) && (nc < (CW+1)'(cols_used));
  assign nbr_row = nr[RW-1:0];
  assign nbr_col = nc[CW-1:0];

endmodule

### hdl/dfs_maze_carver.sv
// Step word: decode, stack-top read, neighbor probe, decide, emit; the probe pace is set by
//   the single read port of the visited map, which probes the four neighbors one a cycle.
// Start word: decode, then the sweep that clears all 2^(clog2(MAX_ROWS)+clog2(MAX_COLS))
//   entries of the visited map one entry a cycle, then seed and emit.
// Finished or bad start: decode, then emit. A held result word stalls emit, and input waits.
// Reset (rst_n low, synchronous) empties the stack, sets 16 x 16 and idles; memories keep data.
// Depends on dmc_pkg, dmc_ram, dmc_nbr and dfs_maze_carver_defines.svh.
`include "dfs_maze_carver_defines.svh"

module dfs_maze_carver #(
  parameter int MAX_ROWS = dmc_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = dmc_pkg::DEF_MAX_COLS
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input words
  input  logic                       in_valid,
  output logic                       in_ready,
  input  dmc_pkg::in_word_t          in_data,
  // result words
  output logic                       out_valid,
  input  logic                       out_ready,
  output dmc_pkg::out_word_t         out_data,
  // register writes
  input  logic                       cfg_we,
  input  logic [dmc_pkg::IDX_W-1:0]  cfg_index,
  input  logic [dmc_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int RW         = $clog2(MAX_ROWS);
  localparam int CW         = $clog2(MAX_COLS);
  localparam int RUW        = $clog2(MAX_ROWS + 1);
  localparam int CUW        = $clog2(MAX_COLS + 1);
  localparam int VAW        = RW + CW;               // visited address: {row, col}
  localparam int VDEPTH     = 1 << VAW;
  localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;   // stack depth
  localparam int SAW        = $clog2(CELL_COUNT);
  localparam int SPW        = $clog2(CELL_COUNT + 1);
  localparam int CMPW       = dmc_pkg::CMP_W;
  localparam int CLW        = dmc_pkg::CELL_W;
  localparam int DW         = dmc_pkg::DEPTH_W;

  // ---------------------------------------------------------------------------
  // Grid size registers and their clamped values (0 acts as 1, above max as max)
  // ---------------------------------------------------------------------------
  logic [dmc_pkg::CFG_W-1:0] cfg_rows_r, cfg_rows_nxt;
  logic [dmc_pkg::CFG_W-1:0] cfg_cols_r, cfg_cols_nxt;
  logic [RUW-1:0]            rows_used;
  logic [CUW-1:0]            cols_used;

  always_comb begin
    cfg_rows_nxt = cfg_rows_r;
    cfg_cols_nxt = cfg_cols_r;
    if (cfg_we) begin
      unique case (cfg_index)
        dmc_pkg::REG_ROWS: cfg_rows_nxt = cfg_wdata;
        dmc_pkg::REG_COLS: cfg_cols_nxt = cfg_wdata;
      endcase
    end
  end

  always_comb begin
    if (cfg_rows_r == '0) begin
      rows_used = RUW'(1);
    end else if (CMPW'(cfg_rows_r) > CMPW'(MAX_ROWS)) begin
      rows_used = RUW'(MAX_ROWS);
    end else begin
      rows_used = RUW'(cfg_rows_r);
    end
    if (cfg_cols_r == '0) begin
      cols_used = CUW'(1);
    end else if (CMPW'(cfg_cols_r) > CMPW'(MAX_COLS)) begin
      cols_used = CUW'(MAX_COLS);
    end else begin
      cols_used = CUW'(cfg_cols_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer state and datapath registers
  // ---------------------------------------------------------------------------
  dmc_pkg::state_t    state_r, state_nxt;
  logic [SPW-1:0]     sp_r, sp_nxt;            // entries on the walk stack
  logic [2:0]         d_r, d_nxt;              // probe counter, 0..5
  logic [3:0]         mask_r, mask_nxt;        // in-grid, unvisited neighbors
  logic               ing_prev_r, ing_prev_nxt;
  logic [RW-1:0]      top_row_r, top_row_nxt;
  logic [CW-1:0]      top_col_r, top_col_nxt;
  logic [VAW-1:0]     clr_r, clr_nxt;          // clearing sweep address
  dmc_pkg::in_word_t  in_r, in_nxt;
  logic [1:0]         rmod3_r, rmod3_nxt;      // random_value mod 3, taken at accept
  dmc_pkg::out_word_t res_r, res_nxt;          // result under construction
  logic               out_valid_r, out_valid_nxt;
  dmc_pkg::out_word_t out_data_r, out_data_nxt;
  logic               load_out;
  logic               in_acc;

  // memory ports
  logic           vis_we;
  logic [VAW-1:0] vis_waddr;
  logic [0:0]     vis_wdata;
  logic [VAW-1:0] vis_raddr;
  logic [0:0]     vis_rdata;
  logic           stk_we;
  logic [SAW-1:0] stk_waddr;
  logic [VAW-1:0] stk_wdata;
  logic [SAW-1:0] stk_raddr;
  logic [VAW-1:0] stk_rdata;

  // shared neighbor unit
  logic [1:0]     nb_dir;
  logic [RW-1:0]  nb_row;
  logic [CW-1:0]  nb_col;
  logic           nb_in;

  // choice among candidates
  logic [2:0]     cand_cnt;
  logic [1:0]     pick;
  logic [1:0]     pick_dir;
  logic [1:0]     seen;
  logic           found;
  logic [1:0]     prev_idx;

  // start cell and its range check
  logic [RW-1:0]  st_row;
  logic [CW-1:0]  st_col;
  logic           start_bad;

  // terms for the checks
  logic           push_chk;
  logic           pop_chk;
  logic           sweep_chk;
  logic           func_start;
  logic           in_emit;

  assign in_ready = (state_r == dmc_pkg::S_IDLE);
  assign in_acc   = in_valid && in_ready;

  assign st_row    = RW'(in_r.start_row);
  assign st_col    = CW'(in_r.start_col);
  assign start_bad = (CMPW'(in_r.start_row) >= CMPW'(rows_used)) ||
                     (CMPW'(in_r.start_col) >= CMPW'(cols_used));

  assign in_nxt    = in_acc ? in_data : in_r;
  assign rmod3_nxt = in_acc ? dmc_pkg::mod3_15(in_data.random_value) : rmod3_r;

  // Neighbor unit serves the probe (dir = counter) and the push (dir = chosen side).
  assign nb_dir   = (state_r == dmc_pkg::S_DECIDE) ? pick_dir : d_r[1:0];
  assign prev_idx = 2'(d_r - 3'd1);

  dmc_nbr #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_nbr (
    .top_row   (top_row_r),
    .top_col   (top_col_r),
    .dir       (nb_dir),
    .rows_used (rows_used),
    .cols_used (cols_used),
    .nbr_row   (nb_row),
    .nbr_col   (nb_col),
    .in_grid   (nb_in)
  );

  // random_value mod count, count being 1..4
  always_comb begin
    cand_cnt = 3'($countones(mask_r));
    unique case (cand_cnt)
      3'd2:    pick = {1'b0, in_r.random_value[0]};
      3'd3:    pick = rmod3_r;
      3'd4:    pick = in_r.random_value[1:0];
      default: pick = 2'd0;
    endcase
  end

  // side of the pick-th candidate in up, down, left, right order
  always_comb begin
    seen     = '0;
    found    = 1'b0;
    pick_dir = dmc_pkg::DIR_UP;
    for (int k = 0; k < 4; k++) begin
      if (mask_r[k] && !found) begin
        if (seen == pick) begin
          pick_dir = 2'(k);
          found    = 1'b1;
        end
        seen = seen + 2'd1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state and memory controls
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt    = state_r;
    sp_nxt       = sp_r;
    d_nxt        = d_r;
    mask_nxt     = mask_r;
    ing_prev_nxt = ing_prev_r;
    top_row_nxt  = top_row_r;
    top_col_nxt  = top_col_r;
    clr_nxt      = clr_r;
    res_nxt      = res_r;
    load_out     = 1'b0;
    vis_we       = 1'b0;
    vis_waddr    = {nb_row, nb_col};
    vis_wdata    = 1'b1;
    vis_raddr    = {nb_row, nb_col};
    stk_we       = 1'b0;
    stk_waddr    = SAW'(sp_r);
    stk_wdata    = {nb_row, nb_col};
    stk_raddr    = SAW'(sp_r - 1'b1);

    unique case (state_r)
      dmc_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = dmc_pkg::S_DECODE;
        end
      end

      dmc_pkg::S_DECODE: begin
        res_nxt.direction   = dmc_pkg::DIR_UP;
        res_nxt.stack_depth = '0;
        if (in_r.func == dmc_pkg::FUNC_START) begin
          if (start_bad) begin
            res_nxt.kind     = dmc_pkg::KIND_BAD;
            res_nxt.cell_row = in_r.start_row;
            res_nxt.cell_col = in_r.start_col;
            state_nxt        = dmc_pkg::S_EMIT;
          end else begin
            clr_nxt   = '0;
            state_nxt = dmc_pkg::S_CLEAR;
          end
        end else if (sp_r == '0) begin
          res_nxt.kind     = dmc_pkg::KIND_FINISHED;
          res_nxt.cell_row = '0;
          res_nxt.cell_col = '0;
          state_nxt        = dmc_pkg::S_EMIT;
        end else begin
          // stack top read is under way
          state_nxt = dmc_pkg::S_TOP;
        end
      end

      dmc_pkg::S_TOP: begin
        top_row_nxt = stk_rdata[VAW-1:CW];
        top_col_nxt = stk_rdata[CW-1:0];
        d_nxt       = '0;
        mask_nxt    = '0;
        state_nxt   = dmc_pkg::S_PROBE;
      end

      dmc_pkg::S_PROBE: begin
        // address of neighbor d goes out, visited bit of neighbor d-1 comes back
        if (d_r != 3'd0) begin
          mask_nxt[prev_idx] = ing_prev_r & ~vis_rdata[0];
        end
        ing_prev_nxt = nb_in;
        d_nxt        = d_r + 3'd1;
        if (d_r == 3'd4) begin
          state_nxt = dmc_pkg::S_DECIDE;
        end
      end

      dmc_pkg::S_DECIDE: begin
        res_nxt.cell_row = CLW'(top_row_r);
        res_nxt.cell_col = CLW'(top_col_r);
        if (mask_r != '0) begin
          vis_we = 1'b1;
          if (sp_r != SPW'(CELL_COUNT)) begin
            stk_we = 1'b1;
            sp_nxt = sp_r + 1'b1;
          end
          res_nxt.kind      = dmc_pkg::KIND_WALL;
          res_nxt.direction = pick_dir;
        end else begin
          sp_nxt            = sp_r - 1'b1;
          res_nxt.kind      = dmc_pkg::KIND_BACK;
          res_nxt.direction = dmc_pkg::DIR_UP;
        end
        state_nxt = dmc_pkg::S_EMIT;
      end

      dmc_pkg::S_CLEAR: begin
        vis_we    = 1'b1;
        vis_waddr = clr_r;
        vis_wdata = 1'b0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == VAW'(VDEPTH - 1)) begin
          state_nxt = dmc_pkg::S_SEED;
        end
      end

      dmc_pkg::S_SEED: begin
        vis_we           = 1'b1;
        vis_waddr        = {st_row, st_col};
        stk_we           = 1'b1;
        stk_waddr        = '0;
        stk_wdata        = {st_row, st_col};
        sp_nxt           = SPW'(1);
        res_nxt.kind     = dmc_pkg::KIND_STARTED;
        res_nxt.cell_row = in_r.start_row;
        res_nxt.cell_col = in_r.start_col;
        state_nxt        = dmc_pkg::S_EMIT;
      end

      dmc_pkg::S_EMIT: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = dmc_pkg::S_IDLE;
        end
      end

      default: state_nxt = dmc_pkg::S_IDLE;
    endcase
  end

  // output register: depth is taken after the stack update
  always_comb begin
    out_data_nxt = out_data_r;
    if (load_out) begin
      out_data_nxt             = res_r;
      out_data_nxt.stack_depth = DW'(sp_r);
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dmc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      out_valid_r <= 1'b0;
      cfg_rows_r  <= dmc_pkg::GRID_RESET;
      cfg_cols_r  <= dmc_pkg::GRID_RESET;
    end else begin
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_rows_r  <= cfg_rows_nxt;
      cfg_cols_r  <= cfg_cols_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r        <= d_nxt;
    mask_r     <= mask_nxt;
    ing_prev_r <= ing_prev_nxt;
    top_row_r  <= top_row_nxt;
    top_col_r  <= top_col_nxt;
    clr_r      <= clr_nxt;
    in_r       <= in_nxt;
    rmod3_r    <= rmod3_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // ---------------------------------------------------------------------------
  // Memories
  // ---------------------------------------------------------------------------
  dmc_ram #(
    .WIDTH (1),
    .DEPTH (VDEPTH)
  ) u_visited (
    .clk   (clk),
    .we    (vis_we),
    .waddr (vis_waddr),
    .wdata (vis_wdata),
    .raddr (vis_raddr),
    .rdata (vis_rdata)
  );

  dmc_ram #(
    .WIDTH (VAW),
    .DEPTH (CELL_COUNT)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  assign push_chk   = (state_r == dmc_pkg::S_DECIDE) && (mask_r != '0);
  assign pop_chk    = (state_r == dmc_pkg::S_DECIDE) && (mask_r == '0);
  assign sweep_chk  = (state_r == dmc_pkg::S_CLEAR);
  assign func_start = (in_r.func == dmc_pkg::FUNC_START);
  assign in_emit    = (state_r == dmc_pkg::S_EMIT);

  `DMC_ASSERT_NOW(a_sp_bound, clk, rst_n, 1'b1, sp_r <= SPW'(CELL_COUNT), "stack overrun")
  `DMC_ASSERT_NEXT(a_push, clk, rst_n, push_chk, sp_r == $past(sp_r) + 1'b1, "push missed")
  `DMC_ASSERT_NEXT(a_pop, clk, rst_n, pop_chk, sp_r == $past(sp_r) - 1'b1, "pop missed")
  `DMC_ASSERT_NOW(a_clear_on_start, clk, rst_n, sweep_chk, func_start, "sweep outside start")
  `DMC_ASSERT_NOW(a_load_from_emit, clk, rst_n, $rose(out_valid_r), $past(in_emit), "stray load")

endmodule

### verif/dmc_walk_checker.sv
`timescale 1ns / 100ps
// Scoreboard for dfs_maze_carver: mirrors the walk state, predicts one event
// word per accepted input word and compares result words in order.
// Depends on dmc_pkg only.
module dmc_walk_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  dmc_pkg::in_word_t         in_data,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  dmc_pkg::out_word_t        out_data,
  input  logic                      cfg_we,
  input  logic [dmc_pkg::IDX_W-1:0] cfg_index,
  input  logic [dmc_pkg::CFG_W-1:0] cfg_wdata,
  output int                        errors,
  output int                        events_waiting
);
  import dmc_pkg::*;

  localparam int ROWS_MAX   = DEF_MAX_ROWS;
  localparam int COLS_MAX   = DEF_MAX_COLS;
  localparam int CELLS      = ROWS_MAX * COLS_MAX;
  localparam int CELL_IDX_W = $clog2(CELLS);

  logic [CFG_W-1:0]      rows_reg;
  logic [CFG_W-1:0]      cols_reg;
  bit                    visited [CELLS];
  logic [CELL_IDX_W-1:0] walk_cells [CELLS];
  int                    depth;
  out_word_t             event_q[$];
  int                    mismatch_count = 0;

  // register value as the block uses it: 0 acts as 1, above max clamps
  function automatic int span(input logic [CFG_W-1:0] v, input int limit);
    if (v == '0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  task automatic clear_visited();
    for (int i = 0; i < CELLS; i++) visited[i] = 1'b0;
  endtask

  task automatic predict_event(input in_word_t w, output out_word_t ev);
    int         rows, cols, row, col, nr, nc, cnt, pick, top;
    logic [1:0] cand_dir [4];
    int         cand_cell [4];
    rows = span(rows_reg, ROWS_MAX);
    cols = span(cols_reg, COLS_MAX);
    ev = '0;
    if (w.func == FUNC_START) begin
      ev.cell_row = w.start_row;
      ev.cell_col = w.start_col;
      if (int'(w.start_row) >= rows || int'(w.start_col) >= cols) begin
        ev.kind = KIND_BAD;
      end else begin
        clear_visited();
        top = int'(w.start_row) * COLS_MAX + int'(w.start_col);
        visited[top] = 1'b1;
        walk_cells[0] = top[CELL_IDX_W-1:0];
        depth = 1;
        ev.kind = KIND_STARTED;
      end
    end else if (depth == 0) begin
      ev.kind = KIND_FINISHED;
    end else begin
      top = int'(walk_cells[depth-1]);
      row = top / COLS_MAX;
      col = top % COLS_MAX;
      cnt = 0;
      // candidates gathered up, down, left, right
      for (int d = 0; d < 4; d++) begin
        nr = row;
        nc = col;
        case (2'(d))
          DIR_UP:   nr = row - 1;
          DIR_DOWN: nr = row + 1;
          DIR_LEFT: nc = col - 1;
          default:  nc = col + 1;
        endcase
        if (nr >= 0 && nr < rows && nc >= 0 && nc < cols) begin
          if (!visited[nr * COLS_MAX + nc]) begin
            cand_dir[cnt]  = 2'(d);
            cand_cell[cnt] = nr * COLS_MAX + nc;
            cnt++;
          end
        end
      end
      ev.cell_row = row[CELL_W-1:0];
      ev.cell_col = col[CELL_W-1:0];
      if (cnt > 0) begin
        pick = int'(w.random_value) % cnt;
        visited[cand_cell[pick]] = 1'b1;
        if (depth < CELLS) begin
          walk_cells[depth] = cand_cell[pick][CELL_IDX_W-1:0];
          depth++;
        end
        ev.kind      = KIND_WALL;
        ev.direction = cand_dir[pick];
      end else begin
        depth--;
        ev.kind = KIND_BACK;
      end
    end
    ev.stack_depth = depth[DEPTH_W-1:0];
  endtask

  task automatic check_field(input string name, input logic [DEPTH_W-1:0] want,
                             input logic [DEPTH_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    out_word_t want;
    if (!rst_n) begin
      rows_reg = GRID_RESET;
      cols_reg = GRID_RESET;
      depth    = 0;
      clear_visited();
      event_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (event_q.size() == 0) begin
          $error("result word with no event pending: kind %0d", out_data.kind);
          mismatch_count++;
        end else begin
          want = event_q.pop_front();
          check_field("kind", DEPTH_W'(want.kind), DEPTH_W'(out_data.kind));
          check_field("cell_row", DEPTH_W'(want.cell_row), DEPTH_W'(out_data.cell_row));
          check_field("cell_col", DEPTH_W'(want.cell_col), DEPTH_W'(out_data.cell_col));
          check_field("direction", DEPTH_W'(want.direction), DEPTH_W'(out_data.direction));
          check_field("stack_depth", want.stack_depth, out_data.stack_depth);
        end
      end
      if (in_valid && in_ready) begin
        predict_event(in_data, want);
        event_q = {event_q, want};
      end
      if (cfg_we) begin
        if (cfg_index == REG_ROWS) rows_reg = cfg_wdata;
        else if (cfg_index == REG_COLS) cols_reg = cfg_wdata;
      end
    end
    errors         <= mismatch_count;
    events_waiting <= event_q.size();
  end

endmodule

### verif/dfs_maze_carver_tb.sv
`timescale 1ns / 100ps
// Top of the maze carver testbench: clock, reset, stimulus and verdict.
// Depends on dmc_pkg, dfs_maze_carver and dmc_walk_checker.
module dfs_maze_carver_tb;
  import dmc_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_word_t           in_data;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_word_t          out_data;
  logic               cfg_we;
  logic [IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]   cfg_wdata;

  // idle odds in percent, per side
  int send_idle;
  int recv_idle;
  int words_sent = 0;
  // long output stall: stimulus bumps hold_req, receiver process counts it out
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int checker_errors;
  int checker_waiting;

  localparam int HOLD_CYCLES = 400;

  dfs_maze_carver dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  dmc_walk_checker walk_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .errors         (checker_errors),
    .events_waiting (checker_waiting)
  );

  // 20 ns period
  always #10 clk = ~clk;

  // Receiver: random back-pressure, or a long hold when one is requested.
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Safety net. A good start sweeps the whole visited map, so the budget
  // is dominated by the number of good starts.
  initial begin
    #(30_000_000);
    $display("Verification failed");
    $finish;
  end

  function automatic in_word_t word_of(input logic f, input int r, input int c,
                                       input int rv);
    in_word_t w;
    w.func         = f;
    w.start_row    = r[CELL_W-1:0];
    w.start_col    = c[CELL_W-1:0];
    w.random_value = rv[14:0];
    return w;
  endfunction

  // start word; the random field is don't-care but still toggled
  function automatic in_word_t start_word(input int r, input int c);
    return word_of(FUNC_START, r, c, $urandom_range(32767));
  endfunction

  // step word; start cell fields are don't-care but still toggled
  function automatic in_word_t step_word(input int rv);
    return word_of(FUNC_STEP, $urandom_range(63), $urandom_range(63), rv);
  endfunction

  // Grid register value: mostly small grids so walks run to the end,
  // sometimes any size, sometimes any raw value (0 and >64 included).
  function automatic logic [CFG_W-1:0] grid_pick();
    case ($urandom_range(7))
      0:       return CFG_W'($urandom_range(127));
      1:       return CFG_W'($urandom_range(1, 64));
      default: return CFG_W'($urandom_range(1, 6));
    endcase
  endfunction

  // Offer one word and hold it until accepted. Valid is only lowered when
  // an idle cycle is actually inserted, so it never drops and rises in the
  // same step.
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  // Stop offering and wait until every predicted event has come out. One
  // result per word, so the block is idle once nothing is pending.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (checker_waiting != 0) @(posedge clk);
  endtask

  // Both grid registers, back to back; only called on an idle block.
  task automatic set_grid(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] c);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ROWS;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_index <= REG_COLS;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic pick_idle_mode();
    if (words_sent < 190) begin
      send_idle = 28;
      recv_idle = 47;
    end else if (words_sent < 350) begin
      send_idle = 47;
      recv_idle = 28;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
  endtask

  initial begin : stimulus
    int               walk;
    int               steps;
    int               er;
    int               ec;
    logic [CFG_W-1:0] gr;
    logic [CFG_W-1:0] gc;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_ROWS;
    cfg_wdata = '0;
    pick_idle_mode();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed ----
    // reset grid is 16 x 16: step on the empty stack, bad start row, bad
    // start col, then a good start in the far corner
    send_word(step_word(0));
    send_word(start_word(16, 0));
    send_word(start_word(0, 16));
    send_word(start_word(15, 15));
    send_word(step_word(0));
    send_word(step_word(32767));

    // full 64 x 64 grid, walk from the bottom-right corner
    drain();
    set_grid(7'd64, 7'd64);
    send_word(start_word(63, 63));
    send_word(step_word(0));
    send_word(step_word(32767));
    send_word(step_word(1));

    // zero acts as one: 1 x 1 grid, out-of-grid start, good start,
    // dead end backtrack, then finished
    drain();
    set_grid(7'd0, 7'd0);
    send_word(start_word(0, 1));
    send_word(start_word(0, 0));
    send_word(step_word($urandom_range(32767)));
    send_word(step_word($urandom_range(32767)));

    // above max clamps to 64
    drain();
    set_grid(7'd127, 7'd127);
    send_word(start_word(63, 0));
    send_word(step_word(32767));
    send_word(step_word(2));

    // shrink the grid mid-walk: the stacked cells now sit outside the grid
    drain();
    set_grid(7'd2, 7'd2);
    send_word(step_word(3));
    send_word(step_word(1));
    send_word(step_word(0));

    // single row, walks only left and right
    drain();
    set_grid(7'd1, 7'd64);
    send_word(start_word(0, 5));
    send_word(step_word(3));
    send_word(step_word(1));
    send_word(step_word(0));

    // ---- random walks ----
    // Each walk: new grid, good start, enough steps to carve and unwind the
    // whole grid (capped), with a sprinkling of stray start words.
    for (walk = 0; walk < 40 && words_sent < 500; walk++) begin
      drain();
      pick_idle_mode();
      gr = grid_pick();
      gc = grid_pick();
      if (walk == 2) begin
        // mid-size grid for the long output stall
        gr = 7'd8;
        gc = 7'd8;
      end
      set_grid(gr, gc);
      er = (gr == 0) ? 1 : ((gr > DEF_MAX_ROWS) ? DEF_MAX_ROWS : int'(gr));
      ec = (gc == 0) ? 1 : ((gc > DEF_MAX_COLS) ? DEF_MAX_COLS : int'(gc));
      send_word(start_word($urandom_range(er - 1), $urandom_range(ec - 1)));
      if (walk == 2) begin
        // let the sweep finish, then stall the output while steps keep
        // coming so the block backs up onto its input
        drain();
        hold_req++;
      end
      steps = 2 * er * ec + $urandom_range(2);
      if (steps > 70) steps = $urandom_range(30, 70);
      for (int s = 0; s < steps; s++) begin
        if (walk % 4 == 3 && s == steps / 2) begin
          // regrid with the walk half done
          drain();
          set_grid(grid_pick(), grid_pick());
        end
        if ($urandom_range(15) == 0) begin
          // stray start, mostly outside the grid
          send_word(start_word($urandom_range(63), $urandom_range(63)));
        end else begin
          send_word(step_word($urandom_range(32767)));
        end
      end
    end

    // ---- wind down ----
    drain();
    repeat (20) @(posedge clk);
    if (checker_errors == 0 && checker_waiting == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
